### hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kinds, character codes and field helpers for the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LINE_BITS     = 16;
  localparam int FIELD_BITS    = 16;
  localparam int MAX_TOKENS    = 3;

  // Scan modes
  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_LINE_COMMENT,
    M_BLOCK, M_BLOCK_STAR, M_STRING, M_NUMBER, M_NUMBER_DOT, M_FRACTION,
    M_IDENT
  } mode_t;

  // Token kinds
  localparam logic [4:0] K_LEFT_PAREN    = 5'd0;
  localparam logic [4:0] K_RIGHT_PAREN   = 5'd1;
  localparam logic [4:0] K_LEFT_BRACE    = 5'd2;
  localparam logic [4:0] K_RIGHT_BRACE   = 5'd3;
  localparam logic [4:0] K_COMMA         = 5'd4;
  localparam logic [4:0] K_DOT           = 5'd5;
  localparam logic [4:0] K_MINUS         = 5'd6;
  localparam logic [4:0] K_PLUS          = 5'd7;
  localparam logic [4:0] K_SEMICOLON     = 5'd8;
  localparam logic [4:0] K_STAR          = 5'd9;
  localparam logic [4:0] K_QUESTION      = 5'd10;
  localparam logic [4:0] K_COLON         = 5'd11;
  localparam logic [4:0] K_BANG          = 5'd12;
  localparam logic [4:0] K_BANG_EQUAL    = 5'd13;
  localparam logic [4:0] K_EQUAL         = 5'd14;
  localparam logic [4:0] K_EQUAL_EQUAL   = 5'd15;
  localparam logic [4:0] K_LESS          = 5'd16;
  localparam logic [4:0] K_LESS_EQUAL    = 5'd17;
  localparam logic [4:0] K_GREATER       = 5'd18;
  localparam logic [4:0] K_GREATER_EQUAL = 5'd19;
  localparam logic [4:0] K_SLASH         = 5'd20;
  localparam logic [4:0] K_STRING        = 5'd21;
  localparam logic [4:0] K_NUMBER        = 5'd22;
  localparam logic [4:0] K_IDENT         = 5'd23;
  localparam logic [4:0] K_EOF           = 5'd24;
  localparam logic [4:0] K_ERR_CHAR      = 5'd25;
  localparam logic [4:0] K_ERR_STRING    = 5'd26;
  localparam logic [4:0] K_ERR_COMMENT   = 5'd27;

  // Character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  typedef struct packed {
    logic [4:0]            kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic [FIELD_BITS-1:0] line;
  } tok_t;

  // Tokens caused by one item, slot 0 first
  typedef struct packed {
    logic [1:0]                  count;
    tok_t [MAX_TOKENS-1:0]       tok;
  } group_t;

  // Build one token in output field form: start masked, length and line
  // saturated to the field width.
  function automatic tok_t mk_tok(logic [4:0] kind,
                                  logic [POSITION_BITS-1:0] st,
                                  logic [POSITION_BITS:0] en,
                                  logic [LINE_BITS-1:0] ln);
    logic [POSITION_BITS:0] st_ext;
    logic [POSITION_BITS:0] diff;
    logic [32:0]            diff_w;
    logic [32:0]            st_w;
    logic [32:0]            ln_w;
    tok_t                   t;
    st_ext   = {1'b0, st};
    diff     = (en > st_ext) ? (en - st_ext) : '0;
    diff_w   = 33'(diff);
    st_w     = 33'(st);
    ln_w     = 33'(ln);
    t.kind   = kind;
    t.start  = st_w[FIELD_BITS-1:0];
    t.length = (diff_w > 33'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}}
                                                   : diff_w[FIELD_BITS-1:0];
    t.line   = (ln_w > 33'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}}
                                                 : ln_w[FIELD_BITS-1:0];
    return t;
  endfunction

endpackage

### hw/rtl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Scan state and token decode: turns one registered byte (or end of source)
// into a group of up to three tokens and advances the scan state.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       char_code,
  input  logic             end_of_source,
  output stt_pkg::group_t  grp
);

  stt_pkg::mode_t                     mode, mode_next;
  logic [stt_pkg::POSITION_BITS-1:0]  byte_position, byte_position_next;
  logic [stt_pkg::POSITION_BITS-1:0]  lexeme_start, lexeme_start_next;
  logic [stt_pkg::LINE_BITS-1:0]      line_count, line_count_next;
  logic [stt_pkg::LINE_BITS-1:0]      comment_line, comment_line_next;

  logic [stt_pkg::POSITION_BITS-1:0]  dot;
  logic [stt_pkg::POSITION_BITS:0]    pos_ext, pos_inc, dot_ext, dot_inc;
  logic [stt_pkg::LINE_BITS-1:0]      line_inc;
  logic                               again;
  logic [1:0]                         f_cnt;
  stt_pkg::tok_t                      f0, f1, t;
  logic                               t_v;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= stt_pkg::CH_ZERO) && (c <= stt_pkg::CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= stt_pkg::CH_LOW_A) && (c <= stt_pkg::CH_LOW_Z)) ||
           ((c >= stt_pkg::CH_UP_A) && (c <= stt_pkg::CH_UP_Z)) ||
           (c == stt_pkg::CH_UNDER);
  endfunction

  function automatic logic [4:0] pair_base(stt_pkg::mode_t m);
    unique case (m)
      stt_pkg::M_BANG:  return stt_pkg::K_BANG;
      stt_pkg::M_EQUAL: return stt_pkg::K_EQUAL;
      stt_pkg::M_LESS:  return stt_pkg::K_LESS;
      default:          return stt_pkg::K_GREATER;
    endcase
  endfunction

  function automatic logic [4:0] pair_eq(stt_pkg::mode_t m);
    unique case (m)
      stt_pkg::M_BANG:  return stt_pkg::K_BANG_EQUAL;
      stt_pkg::M_EQUAL: return stt_pkg::K_EQUAL_EQUAL;
      stt_pkg::M_LESS:  return stt_pkg::K_LESS_EQUAL;
      default:          return stt_pkg::K_GREATER_EQUAL;
    endcase
  endfunction

  // Shared position arithmetic
  assign pos_ext  = {1'b0, byte_position};
  assign pos_inc  = pos_ext + 1'b1;
  assign dot      = (byte_position > lexeme_start) ? (byte_position - 1'b1)
                                                   : lexeme_start;
  assign dot_ext  = {1'b0, dot};
  assign dot_inc  = dot_ext + 1'b1;
  assign line_inc = (line_count == {stt_pkg::LINE_BITS{1'b1}}) ? line_count
                                                               : line_count + 1'b1;

  // Hold the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= stt_pkg::M_IDLE;
      byte_position <= '0;
      lexeme_start  <= '0;
      line_count    <= stt_pkg::LINE_BITS'(1);
      comment_line  <= stt_pkg::LINE_BITS'(1);
    end else if (advance) begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
      lexeme_start  <= lexeme_start_next;
      line_count    <= line_count_next;
      comment_line  <= comment_line_next;
    end
  end

  // Decode the byte against the pending token
  always_comb begin
    mode_next          = mode;
    byte_position_next = byte_position;
    lexeme_start_next  = lexeme_start;
    line_count_next    = line_count;
    comment_line_next  = comment_line;
    again              = 1'b0;
    f_cnt              = 2'd0;
    f0                 = '0;
    f1                 = '0;
    t_v                = 1'b0;
    t                  = '0;

    if (end_of_source) begin
      // flush the pending token, then end of file
      unique case (mode)
        stt_pkg::M_BANG, stt_pkg::M_EQUAL, stt_pkg::M_LESS, stt_pkg::M_GREATER: begin
          f_cnt = 2'd1;
          f0 = stt_pkg::mk_tok(pair_base(mode), lexeme_start, pos_ext, line_count);
        end
        stt_pkg::M_SLASH: begin
          f_cnt = 2'd1;
          f0 = stt_pkg::mk_tok(stt_pkg::K_SLASH, lexeme_start, pos_ext, line_count);
        end
        stt_pkg::M_BLOCK, stt_pkg::M_BLOCK_STAR: begin
          f_cnt = 2'd1;
          f0 = stt_pkg::mk_tok(stt_pkg::K_ERR_COMMENT, lexeme_start, pos_ext,
                               comment_line);
        end
        stt_pkg::M_STRING: begin
          f_cnt = 2'd1;
          f0 = stt_pkg::mk_tok(stt_pkg::K_ERR_STRING, lexeme_start, pos_ext,
                               line_count);
        end
        stt_pkg::M_NUMBER, stt_pkg::M_FRACTION: begin
          f_cnt = 2'd1;
          f0 = stt_pkg::mk_tok(stt_pkg::K_NUMBER, lexeme_start, pos_ext, line_count);
        end
        stt_pkg::M_NUMBER_DOT: begin
          f_cnt = 2'd2;
          f0 = stt_pkg::mk_tok(stt_pkg::K_NUMBER, lexeme_start, dot_ext, line_count);
          f1 = stt_pkg::mk_tok(stt_pkg::K_DOT, dot, dot_inc, line_count);
        end
        stt_pkg::M_IDENT: begin
          f_cnt = 2'd1;
          f0 = stt_pkg::mk_tok(stt_pkg::K_IDENT, lexeme_start, pos_ext, line_count);
        end
        default: begin
        end
      endcase
      t_v = 1'b1;
      t   = stt_pkg::mk_tok(stt_pkg::K_EOF, byte_position, pos_ext, line_count);
      // restart the counters
      mode_next          = stt_pkg::M_IDLE;
      byte_position_next = '0;
      lexeme_start_next  = '0;
      line_count_next    = stt_pkg::LINE_BITS'(1);
      comment_line_next  = stt_pkg::LINE_BITS'(1);
    end else begin
      unique case (mode)
        stt_pkg::M_BANG, stt_pkg::M_EQUAL, stt_pkg::M_LESS, stt_pkg::M_GREATER: begin
          if (char_code == stt_pkg::CH_EQUAL) begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(pair_eq(mode), lexeme_start, pos_inc, line_count);
            mode_next = stt_pkg::M_IDLE;
          end else begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(pair_base(mode), lexeme_start, pos_ext, line_count);
            again = 1'b1;
          end
        end
        stt_pkg::M_SLASH: begin
          if (char_code == stt_pkg::CH_SLASH) begin
            mode_next = stt_pkg::M_LINE_COMMENT;
          end else if (char_code == stt_pkg::CH_STAR) begin
            mode_next         = stt_pkg::M_BLOCK;
            comment_line_next = line_count;
          end else begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(stt_pkg::K_SLASH, lexeme_start, pos_ext, line_count);
            again = 1'b1;
          end
        end
        stt_pkg::M_LINE_COMMENT: begin
          again = (char_code == stt_pkg::CH_LF);
        end
        stt_pkg::M_BLOCK: begin
          if (char_code == stt_pkg::CH_STAR) begin
            mode_next = stt_pkg::M_BLOCK_STAR;
          end else if (char_code == stt_pkg::CH_LF) begin
            line_count_next = line_inc;
          end
        end
        stt_pkg::M_BLOCK_STAR: begin
          if (char_code == stt_pkg::CH_SLASH) begin
            mode_next = stt_pkg::M_IDLE;
          end else if (char_code != stt_pkg::CH_STAR) begin
            if (char_code == stt_pkg::CH_LF) begin
              line_count_next = line_inc;
            end
            mode_next = stt_pkg::M_BLOCK;
          end
        end
        stt_pkg::M_STRING: begin
          if (char_code == stt_pkg::CH_QUOTE) begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(stt_pkg::K_STRING, lexeme_start, pos_inc, line_count);
            mode_next = stt_pkg::M_IDLE;
          end else if (char_code == stt_pkg::CH_LF) begin
            line_count_next = line_inc;
          end
        end
        stt_pkg::M_NUMBER: begin
          if (char_code == stt_pkg::CH_DOT) begin
            mode_next = stt_pkg::M_NUMBER_DOT;
          end else if (!is_digit(char_code)) begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(stt_pkg::K_NUMBER, lexeme_start, pos_ext, line_count);
            again = 1'b1;
          end
        end
        stt_pkg::M_NUMBER_DOT: begin
          if (is_digit(char_code)) begin
            mode_next = stt_pkg::M_FRACTION;
          end else begin
            f_cnt = 2'd2;
            f0 = stt_pkg::mk_tok(stt_pkg::K_NUMBER, lexeme_start, dot_ext, line_count);
            f1 = stt_pkg::mk_tok(stt_pkg::K_DOT, dot, dot_inc, line_count);
            again = 1'b1;
          end
        end
        stt_pkg::M_FRACTION: begin
          if (!is_digit(char_code)) begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(stt_pkg::K_NUMBER, lexeme_start, pos_ext, line_count);
            again = 1'b1;
          end
        end
        stt_pkg::M_IDENT: begin
          if (!is_alpha(char_code) && !is_digit(char_code)) begin
            f_cnt = 2'd1;
            f0 = stt_pkg::mk_tok(stt_pkg::K_IDENT, lexeme_start, pos_ext, line_count);
            again = 1'b1;
          end
        end
        default: begin
          again = 1'b1;
        end
      endcase

      // rescan the byte from idle
      if (again) begin
        lexeme_start_next = byte_position;
        mode_next         = stt_pkg::M_IDLE;
        case (char_code)
          stt_pkg::CH_LPAREN:  begin t_v = 1'b1; t.kind = stt_pkg::K_LEFT_PAREN;  end
          stt_pkg::CH_RPAREN:  begin t_v = 1'b1; t.kind = stt_pkg::K_RIGHT_PAREN; end
          stt_pkg::CH_LBRACE:  begin t_v = 1'b1; t.kind = stt_pkg::K_LEFT_BRACE;  end
          stt_pkg::CH_RBRACE:  begin t_v = 1'b1; t.kind = stt_pkg::K_RIGHT_BRACE; end
          stt_pkg::CH_COMMA:   begin t_v = 1'b1; t.kind = stt_pkg::K_COMMA;       end
          stt_pkg::CH_DOT:     begin t_v = 1'b1; t.kind = stt_pkg::K_DOT;         end
          stt_pkg::CH_MINUS:   begin t_v = 1'b1; t.kind = stt_pkg::K_MINUS;       end
          stt_pkg::CH_PLUS:    begin t_v = 1'b1; t.kind = stt_pkg::K_PLUS;        end
          stt_pkg::CH_SEMI:    begin t_v = 1'b1; t.kind = stt_pkg::K_SEMICOLON;   end
          stt_pkg::CH_STAR:    begin t_v = 1'b1; t.kind = stt_pkg::K_STAR;        end
          stt_pkg::CH_QUEST:   begin t_v = 1'b1; t.kind = stt_pkg::K_QUESTION;    end
          stt_pkg::CH_COLON:   begin t_v = 1'b1; t.kind = stt_pkg::K_COLON;       end
          stt_pkg::CH_BANG:    mode_next = stt_pkg::M_BANG;
          stt_pkg::CH_EQUAL:   mode_next = stt_pkg::M_EQUAL;
          stt_pkg::CH_LESS:    mode_next = stt_pkg::M_LESS;
          stt_pkg::CH_GREATER: mode_next = stt_pkg::M_GREATER;
          stt_pkg::CH_SLASH:   mode_next = stt_pkg::M_SLASH;
          stt_pkg::CH_SPACE, stt_pkg::CH_CR, stt_pkg::CH_TAB: begin
          end
          stt_pkg::CH_LF:      line_count_next = line_inc;
          stt_pkg::CH_QUOTE:   mode_next = stt_pkg::M_STRING;
          default: begin
            if (is_digit(char_code)) begin
              mode_next = stt_pkg::M_NUMBER;
            end else if (is_alpha(char_code)) begin
              mode_next = stt_pkg::M_IDENT;
            end else begin
              t_v    = 1'b1;
              t.kind = stt_pkg::K_ERR_CHAR;
            end
          end
        endcase
        if (t_v) begin
          t = stt_pkg::mk_tok(t.kind, byte_position, pos_inc, line_count);
        end
      end

      // advance the position, saturating
      byte_position_next = (byte_position == {stt_pkg::POSITION_BITS{1'b1}})
                           ? byte_position : byte_position + 1'b1;
    end
  end

  // Pack the flushed tokens ahead of the new one
  always_comb begin
    grp.count  = f_cnt + {1'b0, t_v};
    grp.tok[0] = (f_cnt != 2'd0) ? f0 : t;
    grp.tok[1] = (f_cnt == 2'd2) ? f1 : t;
    grp.tok[2] = t;
  end

endmodule

### hw/rtl/stt_out.sv
// ----------------------------------------------------------------------------
// stt_out
// Result register: holds one group of tokens and hands them out one
// transfer at a time, taking the next group as the last token leaves.
// ----------------------------------------------------------------------------
module stt_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  stt_pkg::group_t   grp_in,
  output logic              load_ok,
  output logic              tok_valid,
  input  logic              tok_stall,
  output logic [4:0]        token_kind,
  output logic [15:0]       token_start,
  output logic [15:0]       token_length,
  output logic [15:0]       token_line,
  output logic              last_of_run
);

  logic [1:0]                                count;
  logic [1:0]                                idx;
  stt_pkg::tok_t [stt_pkg::MAX_TOKENS-1:0]   toks;
  stt_pkg::tok_t                             cur;
  logic                                      is_last;
  logic                                      take;

  assign tok_valid = (count != 2'd0);
  assign is_last   = (idx == (count - 2'd1));
  assign take      = tok_valid && !tok_stall;
  assign load_ok   = !tok_valid || (take && is_last);

  // Select the token on show
  always_comb begin
    case (idx)
      2'd0:    cur = toks[0];
      2'd1:    cur = toks[1];
      default: cur = toks[2];
    endcase
  end

  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.length;
  assign token_line   = cur.line;
  assign last_of_run  = is_last;

  // Control: load a new group or step through the held one
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      idx   <= 2'd0;
    end else if (load_ok) begin
      count <= load ? grp_in.count : 2'd0;
      idx   <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (load_ok && load) begin
      toks <= grp_in.tok;
    end
  end

endmodule

### hw/rtl/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Byte-serial scanner that turns source text into tokens.
// ----------------------------------------------------------------------------
// One byte (or an end-of-source mark) is taken per cycle unless src_stall is
// high. Each item passes an input register and a single decode step that
// updates the scan state and combinationally builds every token the item
// causes (zero to three); the group then sits in a result register that
// presents one token per transfer, with last_of_run marking the final one.
// The sustained rate is one item per cycle while each item causes at most
// one token and tok_stall stays low; an item causing more holds the output
// until its last token leaves, stalling input. Items causing no token never
// wait on the output. Nothing needs clearing after reset.
module source_text_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_source,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic        last_of_run
);

  logic            item_valid;
  logic [7:0]      item_char;
  logic            item_eos;
  logic            advance;
  logic            load_ok;
  stt_pkg::group_t grp;

  // Move the held item on when its tokens fit or it has none
  assign advance   = item_valid && ((grp.count == 2'd0) || load_ok);
  assign src_stall = item_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!src_stall) begin
      item_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall) begin
      item_char <= char_code;
      item_eos  <= end_of_source;
    end
  end

  stt_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .char_code     (item_char),
    .end_of_source (item_eos),
    .grp           (grp)
  );

  stt_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .grp_in       (grp),
    .load_ok      (load_ok),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_line   (token_line),
    .last_of_run  (last_of_run)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source text tokenizer. A scoreboard keeps its
// own copy of the scan state, predicts the tokens of every byte transfer
// and checks each token transfer against the oldest prediction. Stimulus is
// a short opening text, then random lexemes under several idling and stall
// mixes.
// ----------------------------------------------------------------------------

class token_scoreboard;

  typedef struct packed {
    stt_pkg::tok_t tok;
    logic          last;
  } expected_token_t;

  expected_token_t expected_tokens[$];
  expected_token_t run_tokens[$];
  int              mismatches;

  stt_pkg::mode_t mode;
  logic [15:0]    pos;
  logic [15:0]    line_no;
  logic [15:0]    lex_start;
  logic [15:0]    cmt_line;

  function new();
    mismatches = 0;
    clear_state();
  endfunction

  function void clear_state();
    mode      = stt_pkg::M_IDLE;
    pos       = 16'd0;
    line_no   = 16'd1;
    lex_start = 16'd0;
    cmt_line  = 16'd1;
  endfunction

  // Add one token of this byte's run; length is end minus start, saturated
  function void add_token(logic [4:0] kind, logic [15:0] st, logic [16:0] en,
                          logic [15:0] ln);
    logic [16:0]     span;
    expected_token_t e;
    if (run_tokens.size() >= stt_pkg::MAX_TOKENS) return;
    span       = (en > {1'b0, st}) ? en - {1'b0, st} : 17'd0;
    e.tok.kind   = kind;
    e.tok.start  = st;
    e.tok.length = span[16] ? 16'hFFFF : span[15:0];
    e.tok.line   = ln;
    e.last       = 1'b0;
    run_tokens.push_back(e);
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= stt_pkg::CH_ZERO && c <= stt_pkg::CH_NINE;
  endfunction

  function bit is_alpha(logic [7:0] c);
    return (c >= stt_pkg::CH_LOW_A && c <= stt_pkg::CH_LOW_Z) ||
           (c >= stt_pkg::CH_UP_A && c <= stt_pkg::CH_UP_Z) ||
           c == stt_pkg::CH_UNDER;
  endfunction

  function void bump_line();
    if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
  endfunction

  function logic [4:0] pair_kind();
    case (mode)
      stt_pkg::M_BANG:  return stt_pkg::K_BANG;
      stt_pkg::M_EQUAL: return stt_pkg::K_EQUAL;
      stt_pkg::M_LESS:  return stt_pkg::K_LESS;
      default:          return stt_pkg::K_GREATER;
    endcase
  endfunction

  // Predict the tokens caused by one accepted byte or end-of-source mark
  function void predict_tokens(logic [7:0] c, logic eos);
    logic [15:0] p;
    logic [15:0] s;
    logic [15:0] dot;
    logic [16:0] p0;
    logic [16:0] p1;
    bit          again;
    p     = pos;
    s     = lex_start;
    dot   = (p > s) ? p - 16'd1 : s;
    p0    = {1'b0, p};
    p1    = p0 + 17'd1;
    again = 1'b0;
    run_tokens.delete();

    if (eos) begin
      // flush the pending lexeme, then end of file, then restart counters
      case (mode)
        stt_pkg::M_BANG, stt_pkg::M_EQUAL, stt_pkg::M_LESS, stt_pkg::M_GREATER:
          add_token(pair_kind(), s, p0, line_no);
        stt_pkg::M_SLASH:
          add_token(stt_pkg::K_SLASH, s, p0, line_no);
        stt_pkg::M_BLOCK, stt_pkg::M_BLOCK_STAR:
          add_token(stt_pkg::K_ERR_COMMENT, s, p0, cmt_line);
        stt_pkg::M_STRING:
          add_token(stt_pkg::K_ERR_STRING, s, p0, line_no);
        stt_pkg::M_NUMBER, stt_pkg::M_FRACTION:
          add_token(stt_pkg::K_NUMBER, s, p0, line_no);
        stt_pkg::M_NUMBER_DOT: begin
          add_token(stt_pkg::K_NUMBER, s, {1'b0, dot}, line_no);
          add_token(stt_pkg::K_DOT, dot, {1'b0, dot} + 17'd1, line_no);
        end
        stt_pkg::M_IDENT:
          add_token(stt_pkg::K_IDENT, s, p0, line_no);
        default: ;
      endcase
      add_token(stt_pkg::K_EOF, p, p0, line_no);
      clear_state();
    end else begin
      // advance the pending lexeme
      case (mode)
        stt_pkg::M_BANG, stt_pkg::M_EQUAL, stt_pkg::M_LESS, stt_pkg::M_GREATER: begin
          if (c == stt_pkg::CH_EQUAL) begin
            add_token(pair_kind() + 5'd1, s, p1, line_no);
            mode = stt_pkg::M_IDLE;
          end else begin
            add_token(pair_kind(), s, p0, line_no);
            again = 1'b1;
          end
        end
        stt_pkg::M_SLASH: begin
          if (c == stt_pkg::CH_SLASH) begin
            mode = stt_pkg::M_LINE_COMMENT;
          end else if (c == stt_pkg::CH_STAR) begin
            mode     = stt_pkg::M_BLOCK;
            cmt_line = line_no;
          end else begin
            add_token(stt_pkg::K_SLASH, s, p0, line_no);
            again = 1'b1;
          end
        end
        stt_pkg::M_LINE_COMMENT: begin
          if (c == stt_pkg::CH_LF) again = 1'b1;
        end
        stt_pkg::M_BLOCK: begin
          if (c == stt_pkg::CH_STAR) mode = stt_pkg::M_BLOCK_STAR;
          else if (c == stt_pkg::CH_LF) bump_line();
        end
        stt_pkg::M_BLOCK_STAR: begin
          if (c == stt_pkg::CH_SLASH) begin
            mode = stt_pkg::M_IDLE;
          end else if (c != stt_pkg::CH_STAR) begin
            if (c == stt_pkg::CH_LF) bump_line();
            mode = stt_pkg::M_BLOCK;
          end
        end
        stt_pkg::M_STRING: begin
          if (c == stt_pkg::CH_QUOTE) begin
            add_token(stt_pkg::K_STRING, s, p1, line_no);
            mode = stt_pkg::M_IDLE;
          end else if (c == stt_pkg::CH_LF) begin
            bump_line();
          end
        end
        stt_pkg::M_NUMBER: begin
          if (c == stt_pkg::CH_DOT) begin
            mode = stt_pkg::M_NUMBER_DOT;
          end else if (!is_digit(c)) begin
            add_token(stt_pkg::K_NUMBER, s, p0, line_no);
            again = 1'b1;
          end
        end
        stt_pkg::M_NUMBER_DOT: begin
          if (is_digit(c)) begin
            mode = stt_pkg::M_FRACTION;
          end else begin
            add_token(stt_pkg::K_NUMBER, s, {1'b0, dot}, line_no);
            add_token(stt_pkg::K_DOT, dot, {1'b0, dot} + 17'd1, line_no);
            again = 1'b1;
          end
        end
        stt_pkg::M_FRACTION: begin
          if (!is_digit(c)) begin
            add_token(stt_pkg::K_NUMBER, s, p0, line_no);
            again = 1'b1;
          end
        end
        stt_pkg::M_IDENT: begin
          if (!is_alpha(c) && !is_digit(c)) begin
            add_token(stt_pkg::K_IDENT, s, p0, line_no);
            again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase

      // rescan the byte from idle
      if (again) begin
        lex_start = p;
        mode      = stt_pkg::M_IDLE;
        case (c)
          stt_pkg::CH_LPAREN:  add_token(stt_pkg::K_LEFT_PAREN, p, p1, line_no);
          stt_pkg::CH_RPAREN:  add_token(stt_pkg::K_RIGHT_PAREN, p, p1, line_no);
          stt_pkg::CH_LBRACE:  add_token(stt_pkg::K_LEFT_BRACE, p, p1, line_no);
          stt_pkg::CH_RBRACE:  add_token(stt_pkg::K_RIGHT_BRACE, p, p1, line_no);
          stt_pkg::CH_COMMA:   add_token(stt_pkg::K_COMMA, p, p1, line_no);
          stt_pkg::CH_DOT:     add_token(stt_pkg::K_DOT, p, p1, line_no);
          stt_pkg::CH_MINUS:   add_token(stt_pkg::K_MINUS, p, p1, line_no);
          stt_pkg::CH_PLUS:    add_token(stt_pkg::K_PLUS, p, p1, line_no);
          stt_pkg::CH_SEMI:    add_token(stt_pkg::K_SEMICOLON, p, p1, line_no);
          stt_pkg::CH_STAR:    add_token(stt_pkg::K_STAR, p, p1, line_no);
          stt_pkg::CH_QUEST:   add_token(stt_pkg::K_QUESTION, p, p1, line_no);
          stt_pkg::CH_COLON:   add_token(stt_pkg::K_COLON, p, p1, line_no);
          stt_pkg::CH_BANG:    mode = stt_pkg::M_BANG;
          stt_pkg::CH_EQUAL:   mode = stt_pkg::M_EQUAL;
          stt_pkg::CH_LESS:    mode = stt_pkg::M_LESS;
          stt_pkg::CH_GREATER: mode = stt_pkg::M_GREATER;
          stt_pkg::CH_SLASH:   mode = stt_pkg::M_SLASH;
          stt_pkg::CH_SPACE, stt_pkg::CH_CR, stt_pkg::CH_TAB: ;
          stt_pkg::CH_LF:      bump_line();
          stt_pkg::CH_QUOTE:   mode = stt_pkg::M_STRING;
          default: begin
            if (is_digit(c)) mode = stt_pkg::M_NUMBER;
            else if (is_alpha(c)) mode = stt_pkg::M_IDENT;
            else add_token(stt_pkg::K_ERR_CHAR, p, p1, line_no);
          end
        endcase
      end
      if (pos != 16'hFFFF) pos = pos + 16'd1;
    end

    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
    foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
  endfunction

  // Compare one token transfer with the oldest prediction
  function void check_token(logic [4:0] kind, logic [15:0] start, logic [15:0] length,
                            logic [15:0] line, logic last);
    expected_token_t e;
    if (expected_tokens.size() == 0) begin
      $error("token with nothing expected: kind %0d start %0d length %0d line %0d",
             kind, start, length, line);
      mismatches++;
      return;
    end
    e = expected_tokens.pop_front();
    if (kind !== e.tok.kind) begin
      $error("token_kind: expected %0d, got %0d", e.tok.kind, kind);
      mismatches++;
    end
    if (start !== e.tok.start) begin
      $error("token_start: expected %0d, got %0d", e.tok.start, start);
      mismatches++;
    end
    if (length !== e.tok.length) begin
      $error("token_length: expected %0d, got %0d", e.tok.length, length);
      mismatches++;
    end
    if (line !== e.tok.line) begin
      $error("token_line: expected %0d, got %0d", e.tok.line, line);
      mismatches++;
    end
    if (last !== e.last) begin
      $error("last_of_run: expected %0b, got %0b", e.last, last);
      mismatches++;
    end
  endfunction

endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 150;
  localparam int PHASE_ITEMS  = 23;

  // Opening text: operators, pairs, comments, number with trailing dot,
  // string over two lines, stray bytes, then an open block comment
  localparam logic [7:0] OPENING_TEXT [24] = '{
    stt_pkg::CH_LPAREN, stt_pkg::CH_BANG, stt_pkg::CH_EQUAL, stt_pkg::CH_GREATER,
    stt_pkg::CH_LOW_A, stt_pkg::CH_UNDER, stt_pkg::CH_NINE, stt_pkg::CH_SLASH,
    stt_pkg::CH_STAR, stt_pkg::CH_SLASH, stt_pkg::CH_LF, stt_pkg::CH_STAR,
    stt_pkg::CH_SLASH, stt_pkg::CH_ZERO, stt_pkg::CH_DOT, stt_pkg::CH_SEMI,
    stt_pkg::CH_QUOTE, stt_pkg::CH_LF, stt_pkg::CH_QUOTE, 8'h80, 8'h00, 8'hFF,
    stt_pkg::CH_SLASH, stt_pkg::CH_STAR
  };

  localparam logic [7:0] SINGLE_CHARS [12] = '{
    stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE,
    stt_pkg::CH_COMMA, stt_pkg::CH_DOT, stt_pkg::CH_MINUS, stt_pkg::CH_PLUS,
    stt_pkg::CH_SEMI, stt_pkg::CH_STAR, stt_pkg::CH_QUEST, stt_pkg::CH_COLON
  };

  localparam logic [7:0] PAIR_CHARS [4]  = '{
    stt_pkg::CH_BANG, stt_pkg::CH_EQUAL, stt_pkg::CH_LESS, stt_pkg::CH_GREATER
  };
  localparam logic [7:0] SPACE_CHARS [4] = '{
    stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR, stt_pkg::CH_LF
  };

  logic        clk;
  logic        rst           = 1'b1;
  logic        src_valid     = 1'b0;
  logic        src_stall;
  logic [7:0]  char_code     = 8'd0;
  logic        end_of_source = 1'b0;
  logic        tok_valid;
  logic        tok_stall     = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last_of_run;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;

  token_scoreboard sb = new();

  source_text_tokenizer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .char_code    (char_code),
    .end_of_source(end_of_source),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_line   (token_line),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the token side at the rate of the current phase
  always @(posedge clk) begin
    tok_stall <= ($urandom_range(99) < stall_pct);
  end

  // Note every byte transfer and check every token transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) sb.predict_tokens(char_code, end_of_source);
      if (tok_valid && !tok_stall)
        sb.check_token(token_kind, token_start, token_length, token_line, last_of_run);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid     <= 1'b1;
    char_code     <= c;
    end_of_source <= eos;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_word_char(bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return stt_pkg::CH_LOW_A + 8'(r);
    if (r < 52) return stt_pkg::CH_UP_A + 8'(r - 26);
    if (r == 52) return stt_pkg::CH_UNDER;
    return stt_pkg::CH_ZERO + 8'(r - 53);
  endfunction

  // Send one lexeme with random content; a few are noise or left open
  task automatic send_lexeme();
    int         sel;
    logic [7:0] c;
    sel = $urandom_range(99);
    if (sel < 10) begin
      send_byte(SINGLE_CHARS[$urandom_range(11)], 1'b0);
    end else if (sel < 20) begin
      send_byte(PAIR_CHARS[$urandom_range(3)], 1'b0);
      if ($urandom_range(1)) send_byte(stt_pkg::CH_EQUAL, 1'b0);
    end else if (sel < 32) begin
      repeat ($urandom_range(1, 3))
        send_byte(stt_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
      if ($urandom_range(1)) begin
        send_byte(stt_pkg::CH_DOT, 1'b0);
        repeat ($urandom_range(0, 2))
          send_byte(stt_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end
    end else if (sel < 44) begin
      send_byte(rand_word_char(1'b1), 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(rand_word_char(1'b0), 1'b0);
    end else if (sel < 54) begin
      send_byte(stt_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 4)) begin
        c = 8'($urandom_range(255));
        if (c == stt_pkg::CH_QUOTE || $urandom_range(3) == 0) c = stt_pkg::CH_LF;
        send_byte(c, 1'b0);
      end
      send_byte(stt_pkg::CH_QUOTE, 1'b0);
    end else if (sel < 60) begin
      send_byte(stt_pkg::CH_SLASH, 1'b0);
      send_byte(stt_pkg::CH_SLASH, 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(rand_word_char(1'b0), 1'b0);
      send_byte(stt_pkg::CH_LF, 1'b0);
    end else if (sel < 68) begin
      send_byte(stt_pkg::CH_SLASH, 1'b0);
      send_byte(stt_pkg::CH_STAR, 1'b0);
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(3))
          0:       c = stt_pkg::CH_STAR;
          1:       c = stt_pkg::CH_SLASH;
          2:       c = stt_pkg::CH_LF;
          default: c = stt_pkg::CH_LOW_A;
        endcase
        send_byte(c, 1'b0);
      end
      send_byte(stt_pkg::CH_STAR, 1'b0);
      send_byte(stt_pkg::CH_SLASH, 1'b0);
    end else if (sel < 78) begin
      send_byte(SPACE_CHARS[$urandom_range(3)], 1'b0);
    end else if (sel < 88) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else if (sel < 92) begin
      send_byte(stt_pkg::CH_SLASH, 1'b0);
    end else if (sel < 96) begin
      // open a string or a block comment and leave it open
      if ($urandom_range(1)) begin
        send_byte(stt_pkg::CH_QUOTE, 1'b0);
      end else begin
        send_byte(stt_pkg::CH_SLASH, 1'b0);
        send_byte(stt_pkg::CH_STAR, 1'b0);
      end
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    int start_count;
    int phase;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening text with no idling, closed by end of source
    foreach (OPENING_TEXT[i]) send_byte(OPENING_TEXT[i], 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);

    // Random lexemes, rotating through the idling mixes
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      phase = ((bytes_sent - start_count) / PHASE_ITEMS) % 4;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 45; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      send_lexeme();
    end
    send_byte(8'($urandom_range(255)), 1'b1);
    src_valid <= 1'b0;

    // Drain the remaining tokens, then allow the pipeline to settle
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (sb.expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", sb.expected_tokens.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
